// ----- sv/mtg_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the mesh tangent generator.
// Used by the vertex store, the divider, the square root unit and the top level.
package mtg_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);

  localparam int POS_W = 20;
  localparam int NRM_W = 16;
  localparam int UV_W  = 16;
  localparam int ACC_W = 32;

  // serial divider: 55-bit dividend, 35-bit divisor
  localparam int DIV_NUM_W = 55;
  localparam int DIV_DEN_W = 35;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // serial square root: 64-bit radicand, 32-bit root
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;
  localparam int SQ_CNT_W = $clog2(SQ_OUT_W);

  // fixed-point scaling
  localparam int TAN_FRAC = 16;  // tangent quotient scale
  localparam int RND_SH   = 14;  // Q1.14 renormalization
  localparam int NORM_HI  = 30;  // normalized magnitude lies in [2^29, 2^30)

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_TRI  = 2'd1,
    REQ_READ = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef struct packed {
    logic [UV_W-1:0]  tv;
    logic [UV_W-1:0]  tu;
    logic [NRM_W-1:0] nz;
    logic [NRM_W-1:0] ny;
    logic [NRM_W-1:0] nx;
    logic [POS_W-1:0] pz;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] px;
  } vtx_t;

  typedef struct packed {
    logic [ACC_W-1:0] z;
    logic [ACC_W-1:0] y;
    logic [ACC_W-1:0] x;
  } acc_t;

  typedef struct packed {
    logic              vtx_we;
    logic              acc_we;
    logic [VIDX_W-1:0] waddr;
    logic [VIDX_W-1:0] raddr;
  } store_ctl_t;

endpackage

// ----- sv/mtg_store.sv -----
`timescale 1ns / 1ps
// Per-vertex storage: vertex attributes and tangent accumulators.
// One write and one read address per cycle, registered read data. Uses mtg_pkg.
module mtg_store import mtg_pkg::*; (
  input  logic       clk,
  input  store_ctl_t ctl,
  input  vtx_t       vtx_wdata,
  input  acc_t       acc_wdata,
  output vtx_t       vtx_rdata,
  output acc_t       acc_rdata
);

  vtx_t vtx_mem [MAX_VERTICES];
  acc_t acc_mem [MAX_VERTICES];

  // attribute memory
  always_ff @(posedge clk) begin
    if (ctl.vtx_we) begin
      vtx_mem[ctl.waddr] <= vtx_wdata;
    end
    vtx_rdata <= vtx_mem[ctl.raddr];
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (ctl.acc_we) begin
      acc_mem[ctl.waddr] <= acc_wdata;
    end
    acc_rdata <= acc_mem[ctl.raddr];
  end

endmodule

// ----- sv/mtg_div.sv -----
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Widths from mtg_pkg.
module mtg_div import mtg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dsr;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, quo[DIV_NUM_W-1]};
    fits  = (trial >= {1'b0, dsr});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && run && (cnt == DIV_CNT_W'(DIV_NUM_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // datapath: quo holds the remaining dividend bits, then the quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= den;
      quo <= num;
    end else if (run) begin
      rem <= fits ? DIV_DEN_W'(trial - {1'b0, dsr}) : DIV_DEN_W'(trial);
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

// ----- sv/mtg_sqrt.sv -----
`timescale 1ns / 1ps
// Integer square root, floor(sqrt(x)), one root bit per cycle.
// Widths from mtg_pkg.
module mtg_sqrt import mtg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SQ_IN_W-1:0]  rad,
  output logic                done,
  output logic [SQ_OUT_W-1:0] root
);

  logic                run;
  logic [SQ_CNT_W-1:0] cnt;
  logic [SQ_IN_W-1:0]  x;
  logic [SQ_IN_W-1:0]  r;
  logic [SQ_IN_W-1:0]  bitr;
  logic [SQ_IN_W-1:0]  trial;

  assign trial = r + bitr;
  assign root  = SQ_OUT_W'(r);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && run && (cnt == SQ_CNT_W'(SQ_OUT_W - 1));
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == SQ_CNT_W'(SQ_OUT_W - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

  // digit-by-digit root
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= rad;
      r    <= '0;
      bitr <= SQ_IN_W'(1) << (SQ_IN_W - 2);
    end else if (run) begin
      if (x >= trial) begin
        x <= x - trial;
        r <= (r >> 1) + bitr;
      end else begin
        r <= r >> 1;
      end
      bitr <= bitr >> 2;
    end
  end

endmodule

// ----- sv/mesh_tangent_generator_unit.sv -----
`timescale 1ns / 1ps
// Mesh tangent generator: per-vertex tangents from triangle position/UV deltas.
// Uses mtg_pkg, mtg_store, mtg_div and mtg_sqrt.
//
// Usage:
//   Input transactions arrive on s_axis; tuser carries the request kind (load
//   vertex, accumulate triangle, read tangent), tdata the indices and vertex
//   attributes. Only a read produces an output transaction on m_axis.
//   s_axis_tready is high only while the sequencer is idle; one request is
//   worked on at a time with a single shared multiplier, a bit-serial
//   divider and a bit-serial square root.
//   Per request: a load writes the vertex in a single state; a triangle is
//   dominated by its three tangent divides and ends early when the UV
//   determinant is zero; a read runs a normalize shift, the root and three
//   divides, and ends early when the tangent has zero length.
//   The result sits in an output register; the next request is accepted
//   while it waits. A read that finishes while the previous result is still
//   held stalls until m_axis_tready takes it.
//   Reset (rst, synchronous) clears the sequencer and the output valid; the
//   vertex memories are not cleared and must be loaded before use.
module mesh_tangent_generator_unit import mtg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vert_a[9:0] vert_b[19:10] vert_c[29:20] pos_x[49:30] pos_y[69:50] pos_z[89:70]
  // norm_x[105:90] norm_y[121:106] norm_z[137:122] tex_u[153:138] tex_v[169:154]
  input  logic [175:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // vertex_id[9:0] tan_x[25:10] tan_y[41:26] tan_z[57:42]
  output logic [63:0]  m_axis_tdata,
  // zero_length[0]
  output logic [0:0]   m_axis_tuser
);

  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_LOAD   = 16'h0002,
    ST_TRA    = 16'h0004,
    ST_TRB    = 16'h0008,
    ST_TRC    = 16'h0010,
    ST_TRD    = 16'h0020,
    ST_MAC    = 16'h0040,
    ST_MACEND = 16'h0080,
    ST_DIVW   = 16'h0100,
    ST_CRD    = 16'h0200,
    ST_CWR    = 16'h0400,
    ST_RRD    = 16'h0800,
    ST_RCAP   = 16'h1000,
    ST_NORM   = 16'h2000,
    ST_QST    = 16'h4000,
    ST_EMIT   = 16'h8000
  } state_t;

  typedef enum logic [2:0] {
    PH_DET, PH_NUM, PH_DOT, PH_ND, PH_SQ, PH_Q
  } phase_t;

  state_t state;
  phase_t ph;
  logic [1:0] cnt;
  logic [1:0] sel;
  logic       sqw;

  logic [9:0] va, vb, vc;
  vtx_t       in_vtx;
  vtx_t       a_vtx;

  logic signed [20:0] e1 [3];
  logic signed [20:0] e2 [3];
  logic signed [16:0] s1, t1, s2, t2;
  logic signed [35:0] det;
  logic               neg;
  logic signed [31:0] tng [3];

  logic signed [15:0] nv [3];
  logic signed [31:0] tv [3];
  logic signed [35:0] d;
  logic signed [37:0] cv [3];
  logic [37:0]        u [3];
  logic [31:0]        len;
  logic signed [15:0] qv [3];
  logic               zero;

  logic signed [31:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [67:0] mul_p;
  logic signed [67:0] acc;
  logic signed [67:0] acc_n;
  logic               sub;

  logic [9:0] out_id;
  logic       out_valid;

  store_ctl_t ctl;
  vtx_t       vtx_rdata;
  acc_t       acc_rdata;
  acc_t       acc_wdata;
  acc_t       acc_sum;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic                 sq_start;
  logic                 sq_done;
  logic [SQ_OUT_W-1:0]  sq_root;

  logic [9:0]  in_a, in_b, in_c;
  logic [9:0]  corner;
  logic [37:0] u_or;
  logic [1:0]  mac_len;

  // ---------------------------------------------------------------- helpers
  function automatic logic [67:0] mag68(input logic signed [67:0] x);
    return x[67] ? 68'(-x) : 68'(x);
  endfunction

  // round half away from zero, drop RND_SH fraction bits
  function automatic logic signed [67:0] rshr(input logic signed [67:0] x);
    logic [67:0] m;
    m = (mag68(x) + (68'd1 << (RND_SH - 1))) >> RND_SH;
    return x[67] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'($signed(a)) + 33'(b);
    if (s > 33'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (s < -33'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return 32'(s);
  endfunction

  // clamp a tangent quotient and apply its sign
  function automatic logic signed [31:0] tan_clamp(input logic [DIV_NUM_W-1:0] q,
                                                   input logic n);
    logic [31:0] qq;
    if (n) begin
      qq = (q > DIV_NUM_W'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(q);
      return $signed(~qq + 32'd1);
    end
    qq = (q > DIV_NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : 32'(q);
    return $signed(qq);
  endfunction

  function automatic logic idx_ok(input logic [9:0] v);
    return 32'(v) < MAX_VERTICES;
  endfunction

  // ---------------------------------------------------------------- input unpack
  assign in_a = s_axis_tdata[9:0];
  assign in_b = s_axis_tdata[19:10];
  assign in_c = s_axis_tdata[29:20];

  assign s_axis_tready = (state == ST_IDLE);

  // corner being accumulated
  always_comb begin
    unique case (cnt)
      2'd0:    corner = va;
      2'd1:    corner = vb;
      default: corner = vc;
    endcase
  end

  // ---------------------------------------------------------------- store
  always_comb begin
    ctl.vtx_we = (state == ST_LOAD);
    ctl.acc_we = (state == ST_LOAD) || (state == ST_CWR);
    ctl.waddr  = (state == ST_LOAD) ? VIDX_W'(va) : VIDX_W'(corner);
    unique case (state)
      ST_TRA:  ctl.raddr = VIDX_W'(va);
      ST_TRB:  ctl.raddr = VIDX_W'(vb);
      ST_TRC:  ctl.raddr = VIDX_W'(vc);
      ST_RRD:  ctl.raddr = VIDX_W'(va);
      default: ctl.raddr = VIDX_W'(corner);
    endcase
  end

  // saturating accumulate of the triangle tangent
  always_comb begin
    acc_sum.x = sat_add(acc_rdata.x, tng[0]);
    acc_sum.y = sat_add(acc_rdata.y, tng[1]);
    acc_sum.z = sat_add(acc_rdata.z, tng[2]);
    acc_wdata = (state == ST_LOAD) ? '0 : acc_sum;
  end

  mtg_store u_store (
    .clk       (clk),
    .ctl       (ctl),
    .vtx_wdata (in_vtx),
    .acc_wdata (acc_wdata),
    .vtx_rdata (vtx_rdata),
    .acc_rdata (acc_rdata)
  );

  // ---------------------------------------------------------------- shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ph)
      PH_DET: begin
        if (cnt == 2'd0) begin
          mul_a = 32'(s1);
          mul_b = 36'(t2);
        end else begin
          mul_a = 32'(s2);
          mul_b = 36'(t1);
        end
      end
      PH_NUM: begin
        if (cnt == 2'd0) begin
          mul_a = 32'(t2);
          mul_b = 36'(e1[sel]);
        end else begin
          mul_a = 32'(t1);
          mul_b = 36'(e2[sel]);
        end
      end
      PH_DOT: begin
        unique case (cnt)
          2'd0: begin
            mul_a = 32'(nv[0]);
            mul_b = 36'(tv[0]);
          end
          2'd1: begin
            mul_a = 32'(nv[1]);
            mul_b = 36'(tv[1]);
          end
          default: begin
            mul_a = 32'(nv[2]);
            mul_b = 36'(tv[2]);
          end
        endcase
      end
      PH_ND: begin
        mul_a = 32'(nv[sel]);
        mul_b = d;
      end
      PH_SQ: begin
        unique case (cnt)
          2'd0: begin
            mul_a = $signed(32'(u[0]));
            mul_b = $signed(36'(u[0]));
          end
          2'd1: begin
            mul_a = $signed(32'(u[1]));
            mul_b = $signed(36'(u[1]));
          end
          default: begin
            mul_a = $signed(32'(u[2]));
            mul_b = $signed(36'(u[2]));
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // products per phase; second product of det/num is subtracted
  always_comb begin
    unique case (ph)
      PH_DET, PH_NUM: mac_len = 2'd2;
      PH_ND:          mac_len = 2'd1;
      default:        mac_len = 2'd3;
    endcase
    sub   = ((ph == PH_DET) || (ph == PH_NUM)) && (cnt == 2'd2);
    acc_n = ((cnt == 2'd1) ? 68'sd0 : acc) + (sub ? -mul_p : mul_p);
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // ---------------------------------------------------------------- divider and root
  always_comb begin
    div_start = ((state == ST_MACEND) && (ph == PH_NUM)) || (state == ST_QST);
    if (ph == PH_NUM) begin
      div_num = DIV_NUM_W'(mag68(acc) << TAN_FRAC);
      div_den = DIV_DEN_W'(mag68(68'(det)));
    end else begin
      div_num = DIV_NUM_W'({u[sel], 14'b0}) + DIV_NUM_W'(len >> 1);
      div_den = DIV_DEN_W'(len);
    end
    sq_start = (state == ST_MACEND) && (ph == PH_SQ);
    u_or     = u[0] | u[1] | u[2];
  end

  mtg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  mtg_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (SQ_IN_W'(acc)),
    .done  (sq_done),
    .root  (sq_root)
  );

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      ph        <= PH_DET;
      cnt       <= '0;
      sel       <= '0;
      sqw       <= 1'b0;
    end else begin
      // output register drains when taken; a new result is loaded in ST_EMIT
      if (m_axis_tready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            va        <= in_a;
            vb        <= in_b;
            vc        <= in_c;
            in_vtx.px <= s_axis_tdata[49:30];
            in_vtx.py <= s_axis_tdata[69:50];
            in_vtx.pz <= s_axis_tdata[89:70];
            in_vtx.nx <= s_axis_tdata[105:90];
            in_vtx.ny <= s_axis_tdata[121:106];
            in_vtx.nz <= s_axis_tdata[137:122];
            in_vtx.tu <= s_axis_tdata[153:138];
            in_vtx.tv <= s_axis_tdata[169:154];
            unique case (req_t'(s_axis_tuser))
              REQ_LOAD: if (idx_ok(in_a)) state <= ST_LOAD;
              REQ_TRI:  if (idx_ok(in_a) && idx_ok(in_b) && idx_ok(in_c)) state <= ST_TRA;
              REQ_READ: if (idx_ok(in_a)) state <= ST_RRD;
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_LOAD: state <= ST_IDLE;
        // fetch the three corners and form the deltas
        ST_TRA: state <= ST_TRB;
        ST_TRB: begin
          a_vtx <= vtx_rdata;
          state <= ST_TRC;
        end
        ST_TRC: begin
          e1[0] <= 21'($signed(vtx_rdata.px)) - 21'($signed(a_vtx.px));
          e1[1] <= 21'($signed(vtx_rdata.py)) - 21'($signed(a_vtx.py));
          e1[2] <= 21'($signed(vtx_rdata.pz)) - 21'($signed(a_vtx.pz));
          s1    <= 17'($signed(vtx_rdata.tu)) - 17'($signed(a_vtx.tu));
          t1    <= 17'($signed(vtx_rdata.tv)) - 17'($signed(a_vtx.tv));
          state <= ST_TRD;
        end
        ST_TRD: begin
          e2[0] <= 21'($signed(vtx_rdata.px)) - 21'($signed(a_vtx.px));
          e2[1] <= 21'($signed(vtx_rdata.py)) - 21'($signed(a_vtx.py));
          e2[2] <= 21'($signed(vtx_rdata.pz)) - 21'($signed(a_vtx.pz));
          s2    <= 17'($signed(vtx_rdata.tu)) - 17'($signed(a_vtx.tu));
          t2    <= 17'($signed(vtx_rdata.tv)) - 17'($signed(a_vtx.tv));
          ph    <= PH_DET;
          cnt   <= '0;
          state <= ST_MAC;
        end
        // multiply-accumulate over mac_len products
        ST_MAC: begin
          if (cnt != 2'd0) begin
            acc <= acc_n;
          end
          if (cnt == mac_len) begin
            state <= ST_MACEND;
          end else begin
            cnt <= cnt + 2'd1;
          end
        end
        ST_MACEND: begin
          cnt <= '0;
          unique case (ph)
            PH_DET: begin
              det <= 36'(acc);
              sel <= '0;
              ph  <= PH_NUM;
              state <= (acc == 68'sd0) ? ST_IDLE : ST_MAC;
            end
            PH_NUM: begin
              neg   <= acc[67] ^ det[35];
              state <= ST_DIVW;
            end
            PH_DOT: begin
              d     <= 36'(rshr(acc));
              sel   <= '0;
              ph    <= PH_ND;
              state <= ST_MAC;
            end
            PH_ND: begin
              cv[sel] <= 38'(tv[sel]) - 38'(rshr(acc));
              if (sel == 2'd2) begin
                state <= ST_NORM;
                sqw   <= 1'b0;
              end else begin
                sel   <= sel + 2'd1;
                state <= ST_MAC;
              end
            end
            default: begin
              sqw   <= 1'b1;
              state <= ST_NORM;
            end
          endcase
        end
        ST_DIVW: begin
          if (div_done) begin
            if (ph == PH_NUM) begin
              tng[sel] <= tan_clamp(div_quo, neg);
              if (sel == 2'd2) begin
                cnt   <= '0;
                state <= ST_CRD;
              end else begin
                sel   <= sel + 2'd1;
                cnt   <= '0;
                state <= ST_MAC;
              end
            end else begin
              qv[sel] <= cv[sel][37] ? -$signed(16'(div_quo)) : $signed(16'(div_quo));
              if (sel == 2'd2) begin
                state <= ST_EMIT;
              end else begin
                sel   <= sel + 2'd1;
                state <= ST_QST;
              end
            end
          end
        end
        // read-modify-write of each corner accumulator
        ST_CRD: state <= ST_CWR;
        ST_CWR: begin
          if (cnt == 2'd2) begin
            state <= ST_IDLE;
          end else begin
            cnt   <= cnt + 2'd1;
            state <= ST_CRD;
          end
        end
        // read: fetch normal and accumulated tangent
        ST_RRD: state <= ST_RCAP;
        ST_RCAP: begin
          nv[0] <= $signed(vtx_rdata.nx);
          nv[1] <= $signed(vtx_rdata.ny);
          nv[2] <= $signed(vtx_rdata.nz);
          tv[0] <= $signed(acc_rdata.x);
          tv[1] <= $signed(acc_rdata.y);
          tv[2] <= $signed(acc_rdata.z);
          ph    <= PH_DOT;
          cnt   <= '0;
          state <= ST_MAC;
        end
        // zero test, then one-bit-per-cycle normalize; sqw marks waiting on the root
        ST_NORM: begin
          if (sqw) begin
            if (sq_done) begin
              len   <= sq_root;
              sel   <= '0;
              ph    <= PH_Q;
              sqw   <= 1'b0;
              state <= ST_QST;
            end
          end else if (ph == PH_ND) begin
            if ((cv[0] == 38'sd0) && (cv[1] == 38'sd0) && (cv[2] == 38'sd0)) begin
              zero  <= 1'b1;
              qv[0] <= '0;
              qv[1] <= '0;
              qv[2] <= '0;
              state <= ST_EMIT;
            end else begin
              zero <= 1'b0;
              u[0] <= cv[0][37] ? 38'(-cv[0]) : 38'(cv[0]);
              u[1] <= cv[1][37] ? 38'(-cv[1]) : 38'(cv[1]);
              u[2] <= cv[2][37] ? 38'(-cv[2]) : 38'(cv[2]);
              ph   <= PH_SQ;
            end
          end else if (u_or[37:NORM_HI] != '0) begin
            u[0] <= u[0] >> 1;
            u[1] <= u[1] >> 1;
            u[2] <= u[2] >> 1;
          end else if (!u_or[NORM_HI-1]) begin
            u[0] <= u[0] << 1;
            u[1] <= u[1] << 1;
            u[2] <= u[2] << 1;
          end else begin
            cnt   <= '0;
            state <= ST_MAC;
          end
        end
        ST_QST: state <= ST_DIVW;
        ST_EMIT: begin
          if (!out_valid || m_axis_tready) begin
            out_valid    <= 1'b1;
            out_id       <= va;
            m_axis_tdata <= {6'b0, qv[2], qv[1], qv[0], va};
            m_axis_tuser <= zero;
            state        <= ST_IDLE;
          end else if (m_axis_tready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid && (out_id == m_axis_tdata[9:0]);

endmodule

// ----- verif/mesh_tangent_generator_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for mesh_tangent_generator_unit: streams vertex loads,
// triangles, tangent reads and no-op requests, predicts each read result. Depends on mtg_pkg.
module mesh_tangent_generator_unit_tb;
  import mtg_pkg::*;

  typedef struct {
    req_t              kind;
    logic [9:0]        va, vb, vc;
    logic [19:0]       px, py, pz;
    logic [15:0]       nx, ny, nz, tu, tv;
    bit                drain;   // wait for all tangents before going on
    bit                hold;    // start a long receiver hold-off
  } vreq_t;

  typedef struct {
    logic [9:0]  id;
    logic [15:0] tx, ty, tz;
    logic        zl;
  } tan_t;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = REQ_NONE;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [63:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  always #1 clk = ~clk;

  mesh_tangent_generator_unit i_dut (.*);

  // predictor state
  longint pos_mem [1024][3];
  longint nrm_mem [1024][3];
  longint uv_mem  [1024][2];
  longint acc_mem [1024][3];
  bit     loaded  [1024];
  int     loaded_ids [$];

  vreq_t  pending [$];
  tan_t   tangents_due [$];
  vreq_t  cur;
  bit     cur_taken = 0;
  bit     draining = 0;
  bit     hold_req = 0;
  int     hold_cnt = 0;
  int     sent = 0;
  int     errors = 0;
  int     quiet_cycles = 0;

  function automatic longint unsigned magn(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint rshift_round(longint x, int k);
    longint unsigned m;
    m = (magn(x) + (64'd1 << (k - 1))) >> k;
    return x < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint tangent_quot(longint num, longint det);
    longint unsigned q;
    q = (magn(num) << 16) / magn(det);
    if ((num < 0) != (det < 0)) begin
      if (q > 64'd2147483648) q = 64'd2147483648;
      return -longint'(q);
    end
    if (q > 64'd2147483647) q = 64'd2147483647;
    return longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Update the vertex state for one accepted request; queue a tangent on reads.
  task automatic tangent_predict(vreq_t r);
    longint e1[3], e2[3], tg[3], n[3], t[3], cv[3];
    longint s1, t1, s2, t2, det, d;
    longint unsigned u[3], m, len, q;
    int     a, b, c;
    tan_t   res;
    a = int'(r.va); b = int'(r.vb); c = int'(r.vc);
    case (r.kind)
      REQ_LOAD: begin
        pos_mem[a][0] = $signed(r.px); pos_mem[a][1] = $signed(r.py);
        pos_mem[a][2] = $signed(r.pz);
        nrm_mem[a][0] = $signed(r.nx); nrm_mem[a][1] = $signed(r.ny);
        nrm_mem[a][2] = $signed(r.nz);
        uv_mem[a][0] = $signed(r.tu); uv_mem[a][1] = $signed(r.tv);
        for (int i = 0; i < 3; i++) acc_mem[a][i] = 0;
      end
      REQ_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = pos_mem[b][i] - pos_mem[a][i];
          e2[i] = pos_mem[c][i] - pos_mem[a][i];
        end
        s1 = uv_mem[b][0] - uv_mem[a][0];
        t1 = uv_mem[b][1] - uv_mem[a][1];
        s2 = uv_mem[c][0] - uv_mem[a][0];
        t2 = uv_mem[c][1] - uv_mem[a][1];
        det = s1 * t2 - s2 * t1;
        if (det != 0) begin
          for (int i = 0; i < 3; i++) tg[i] = tangent_quot(t2 * e1[i] - t1 * e2[i], det);
          for (int i = 0; i < 3; i++) begin
            acc_mem[a][i] = sat32(acc_mem[a][i] + tg[i]);
            acc_mem[b][i] = sat32(acc_mem[b][i] + tg[i]);
            acc_mem[c][i] = sat32(acc_mem[c][i] + tg[i]);
          end
        end
      end
      REQ_READ: begin
        for (int i = 0; i < 3; i++) begin
          t[i] = acc_mem[a][i];
          n[i] = nrm_mem[a][i];
        end
        d = rshift_round(n[0] * t[0] + n[1] * t[1] + n[2] * t[2], 14);
        for (int i = 0; i < 3; i++) cv[i] = t[i] - rshift_round(n[i] * d, 14);
        res.id = r.va;
        res.zl = (cv[0] == 0 && cv[1] == 0 && cv[2] == 0);
        res.tx = '0; res.ty = '0; res.tz = '0;
        if (!res.zl) begin
          m = 0;
          for (int i = 0; i < 3; i++) begin
            u[i] = magn(cv[i]);
            if (u[i] > m) m = u[i];
          end
          while (m >= (64'd1 << 30)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) u[i] >>= 1;
          end
          while (m < (64'd1 << 29)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) u[i] <<= 1;
          end
          len = int_sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
          for (int i = 0; i < 3; i++) begin
            q = ((u[i] << 14) + (len >> 1)) / len;
            tg[i] = cv[i] < 0 ? -longint'(q) : longint'(q);
          end
          res.tx = tg[0][15:0]; res.ty = tg[1][15:0]; res.tz = tg[2][15:0];
        end
        tangents_due = {tangents_due, res};
      end
      default: ;
    endcase
  endtask

  function automatic vreq_t blank(req_t k);
    vreq_t r;
    r.kind = k;
    r.va = 0; r.vb = 0; r.vc = 0;
    r.px = 0; r.py = 0; r.pz = 0;
    r.nx = 0; r.ny = 0; r.nz = 0; r.tu = 0; r.tv = 0;
    r.drain = 0; r.hold = 0;
    return r;
  endfunction

  function automatic vreq_t mk_load(int id, int x, int y, int z, int nx, int ny, int nz,
                                    int u, int v);
    vreq_t r;
    r = blank(REQ_LOAD);
    r.va = 10'(id); r.px = 20'(x); r.py = 20'(y); r.pz = 20'(z);
    r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz); r.tu = 16'(u); r.tv = 16'(v);
    return r;
  endfunction

  function automatic vreq_t mk_tri(int a, int b, int c);
    vreq_t r;
    r = blank(REQ_TRI);
    r.va = 10'(a); r.vb = 10'(b); r.vc = 10'(c);
    return r;
  endfunction

  function automatic vreq_t mk_read(int a);
    vreq_t r;
    r = blank(REQ_READ);
    r.va = 10'(a);
    return r;
  endfunction

  // queue an item, tracking which vertices hold defined data
  task automatic add_req(vreq_t r);
    if (r.kind == REQ_LOAD && !loaded[r.va]) begin
      loaded[r.va] = 1;
      loaded_ids = {loaded_ids, int'(r.va)};
    end
    pending = {pending, r};
  endtask

  function automatic int pick_vertex();
    return loaded_ids[$urandom_range(loaded_ids.size() - 1)];
  endfunction

  // sender: presents items at the falling edge
  always @(negedge clk) begin
    int idle_pct;
    vreq_t nx;
    idle_pct = sent < 220 ? 38 : (sent < 440 ? 0 : 0);
    if (sent >= 220 && sent < 440) idle_pct = 66;
    if (!rst && (!s_axis_tvalid || cur_taken)) begin
      cur_taken = 0;
      if (draining && tangents_due.size() == 0) draining = 0;
      if (!draining && pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
        nx = pending.pop_front();
        if (nx.hold) hold_req = 1;
        if (nx.drain) begin
          draining = 1;
          s_axis_tvalid <= 0;
        end else begin
          cur = nx;
          sent++;
          s_axis_tvalid <= 1;
          s_axis_tuser  <= nx.kind;
          s_axis_tdata  <= {6'd0, nx.tv, nx.tu, nx.nz, nx.ny, nx.nx,
                            nx.pz, nx.py, nx.px, nx.vc, nx.vb, nx.va};
        end
      end else begin
        s_axis_tvalid <= 0;
      end
    end
  end

  // receiver ready, with its own hold-off counter
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = sent < 220 ? 66 : (sent < 440 ? 38 : 0);
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 3000;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= !rst && $urandom_range(99) >= idle_pct;
    end
  end

  // monitor: accept transactions at the rising edge
  always @(posedge clk) begin
    tan_t exp_t;
    bit moved;
    moved = 0;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      tangent_predict(cur);
      cur_taken = 1;
      moved = 1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      moved = 1;
      if (tangents_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected tangent, actual %h/%h", $time, m_axis_tdata, m_axis_tuser);
      end else begin
        exp_t = tangents_due.pop_front();
        if (m_axis_tdata[9:0] !== exp_t.id || m_axis_tdata[25:10] !== exp_t.tx ||
            m_axis_tdata[41:26] !== exp_t.ty || m_axis_tdata[57:42] !== exp_t.tz ||
            m_axis_tuser[0] !== exp_t.zl) begin
          errors++;
          $display("%0t: mismatch, expected id %0d t %h %h %h z %b, actual id %0d t %h %h %h z %b",
                   $time, exp_t.id, exp_t.tx, exp_t.ty, exp_t.tz, exp_t.zl,
                   m_axis_tdata[9:0], m_axis_tdata[25:10], m_axis_tdata[41:26],
                   m_axis_tdata[57:42], m_axis_tuser[0]);
        end
      end
    end
    // watchdog on cycles without any transaction
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (!rst && quiet_cycles >= 12000) begin
      $display("mesh_tangent_generator_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    vreq_t r;
    int sel;
    // directed: extremes, saturation, zero determinant, repeated corners
    add_req(mk_load(0, 0, 0, 0, 0, 0, 16384, 0, 0));
    add_req(mk_load(1, 524287, 0, 0, 0, 0, 16384, 1, 0));
    add_req(mk_load(2, 0, -524288, 524287, 0, 0, 16384, 0, 1));
    add_req(mk_load(1023, -524288, 524287, -524288, -16384, 16384, -16384, -32768, 32767));
    add_req(mk_load(3, 100, 200, 300, 16384, 0, 0, 32767, -32768));
    add_req(mk_read(0));                          // zero-length tangent
    add_req(mk_tri(0, 1, 2));                     // tangent saturates
    add_req(mk_tri(0, 1, 2));                     // accumulator saturates
    add_req(mk_read(0));
    add_req(mk_read(1023));
    add_req(mk_tri(0, 0, 1));                     // zero determinant
    add_req(mk_tri(1023, 3, 1023));               // repeated corner
    add_req(mk_tri(3, 1023, 2));
    add_req(mk_read(3));
    add_req(mk_read(1023));
    add_req(mk_read(2));
    add_req(mk_load(682, 1, -1, 2, 9000, -9000, 5000, 4096, 8192));
    add_req(mk_tri(682, 3, 1));
    add_req(mk_read(682));
    r = blank(REQ_NONE); r.va = 10'h3FF; r.vb = 10'h3FF; r.vc = 10'h3FF;
    add_req(r);
    add_req(mk_read(1));
    r = blank(REQ_READ); r.drain = 1;
    add_req(r);
    r = mk_read(0); r.hold = 1;  // start hold-off, sender keeps going
    add_req(r);
    // random: mostly triangles and reads over a small working set
    for (int k = 0; k < 630; k++) begin
      sel = $urandom_range(99);
      if (sel < 22) begin
        add_req(mk_load($urandom_range(3) == 0 ? $urandom_range(1023) : $urandom_range(23),
                        $urandom_range(1048575), $urandom_range(1048575),
                        $urandom_range(1048575),
                        $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                        $urandom_range(32768) - 16384,
                        $urandom_range(65535), $urandom_range(65535)));
      end else if (sel < 65) begin
        add_req(mk_tri(pick_vertex(), pick_vertex(), pick_vertex()));
      end else if (sel < 96) begin
        add_req(mk_read(pick_vertex()));
      end else begin
        r = blank(REQ_NONE);
        r.va = 10'($urandom); r.px = 20'($urandom);
        add_req(r);
      end
    end
    repeat (10) @(posedge clk);
    rst <= 0;
    while (pending.size() > 0 || s_axis_tvalid || tangents_due.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && tangents_due.size() == 0)
      $display("mesh_tangent_generator_unit_tb OK");
    else
      $display("mesh_tangent_generator_unit_tb NOT OK");
    $finish;
  end

endmodule

// ----- mesh_tangent_generator_unit.f -----
sv/mtg_pkg.sv
sv/mtg_store.sv
sv/mtg_div.sv
sv/mtg_sqrt.sv
sv/mesh_tangent_generator_unit.sv
verif/mesh_tangent_generator_unit_tb.sv
